// ===== rtl/quicksort_hoare_sorter_defines.svh =====
// Assertion macros for the quicksort sorter block.
// Used by files that hold concurrent checks; needs a clock i_clk and reset i_rst_n in scope.
`ifndef QUICKSORT_HOARE_SORTER_DEFINES_SVH
`define QUICKSORT_HOARE_SORTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define QHS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qhs: same-cycle check failed");

// next-cycle implication, disabled during reset
`define QHS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qhs: next-cycle check failed");

`endif

// ===== rtl/qhs_pkg.sv =====
// Shared constants for the quicksort sorter: default store depth and data width.
// No dependencies; imported by the RAM and the top level.
package qhs_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;

endpackage

// ===== rtl/qhs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on qhs_pkg for parameter defaults.
module qhs_ram #(
    parameter int WIDTH = qhs_pkg::DATA_WIDTH_DEFAULT,
    parameter int DEPTH = qhs_pkg::DEPTH_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    import qhs_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/quicksort_hoare_sorter.sv =====
// Load: one beat per cycle. Sort: Hoare partition on one shared signed comparator; each
// pointer step reads then compares an element, a swap writes both; run time is data
// dependent, quadratic in the worst case. Output: each beat is read, registered and held
// until taken before the next is read. Ready is low from the last input beat until the
// final result beat is taken. Reset (synchronous, active low) clears count, overflow flag,
// stack pointer and FSM; element and range stores are not cleared and need no clearing pass.
module quicksort_hoare_sorter #(
    parameter int DEPTH      = qhs_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = qhs_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic                         i_last_item,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_sorted_value,
    output logic                         o_last_out,
    output logic                         o_overflowed
);
    import qhs_pkg::*;
    `include "quicksort_hoare_sorter_defines.svh"

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = IW + 2;

    typedef enum logic [4:0] {
        S_LOAD, S_START, S_PIV_RD, S_PIV_GET, S_LOOP,
        S_L_RD, S_L_CHK, S_H_RD, S_H_CHK, S_SWAP_L, S_SWAP_H,
        S_PUSH1, S_PUSH2, S_POP, S_POP_GET,
        S_OUT_RD, S_OUT_GET, S_OUT_WAIT
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_ovf, n_ovf;
    logic [CW-1:0]              r_sp, n_sp;
    logic [CW-1:0]              r_k, n_k;
    logic [IW-1:0]              r_lo, n_lo, r_hi, n_hi;
    logic signed [PW-1:0]       r_l, n_l, r_h, n_h;
    logic [DATA_WIDTH-1:0]      r_pivot, n_pivot, r_vl, n_vl, r_vh, n_vh;
    logic                       r_o_valid, n_o_valid, r_o_last, n_o_last, r_o_ovf, n_o_ovf;
    logic [DATA_WIDTH-1:0]      r_o_data, n_o_data;

    logic                       el_we;
    logic [IW-1:0]              el_waddr, el_raddr;
    logic [DATA_WIDTH-1:0]      el_wdata, el_rdata;
    logic                       stk_we;
    logic [IW-1:0]              stk_waddr, stk_raddr;
    logic [2*IW-1:0]            stk_wdata, stk_rdata;

    logic signed [PW-1:0]       s_lo, s_hi, pa, pb;
    logic                       big_left, first_left, push_ok;
    logic [CW-1:0]              cnt_m1, sp_m1;
    logic [IW:0]                mid_sum;
    logic signed [DATA_WIDTH-1:0] cmp_a, cmp_b;
    logic                       cmp_lt;

    qhs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (el_we),
        .i_waddr (el_waddr),
        .i_wdata (el_wdata),
        .i_raddr (el_raddr),
        .o_rdata (el_rdata)
    );

    qhs_ram #(.WIDTH(2 * IW), .DEPTH(DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign s_lo    = $signed({2'b00, r_lo});
    assign s_hi    = $signed({2'b00, r_hi});
    assign cnt_m1  = r_count - CW'(1);
    assign sp_m1   = r_sp - CW'(1);
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};

    // shared signed comparator: element < pivot on the low scan, pivot < element on the high
    assign cmp_a  = (r_state == S_L_CHK) ? $signed(el_rdata) : $signed(r_pivot);
    assign cmp_b  = (r_state == S_L_CHK) ? $signed(r_pivot) : $signed(el_rdata);
    assign cmp_lt = cmp_a < cmp_b;

    // larger part goes on the stack first
    assign big_left   = (r_h - s_lo) > (s_hi - r_l);
    assign first_left = (r_state == S_PUSH1) ? big_left : !big_left;
    assign pa         = first_left ? s_lo : r_l;
    assign pb         = first_left ? r_h : s_hi;
    assign push_ok    = (pa < pb) && (r_sp < CW'(DEPTH));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_sp      = r_sp;
        n_k       = r_k;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_l       = r_l;
        n_h       = r_h;
        n_pivot   = r_pivot;
        n_vl      = r_vl;
        n_vh      = r_vh;
        n_o_valid = r_o_valid;
        n_o_last  = r_o_last;
        n_o_ovf   = r_o_ovf;
        n_o_data  = r_o_data;
        el_we     = 1'b0;
        el_waddr  = r_count[IW-1:0];
        el_wdata  = i_value;
        el_raddr  = r_l[IW-1:0];
        stk_we    = 1'b0;
        stk_waddr = r_sp[IW-1:0];
        stk_wdata = {pa[IW-1:0], pb[IW-1:0]};
        stk_raddr = sp_m1[IW-1:0];
        case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (r_count < CW'(DEPTH)) begin
                        el_we   = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_item) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_sp    = '0;
                n_lo    = '0;
                n_hi    = cnt_m1[IW-1:0];
                n_state = (r_count >= CW'(2)) ? S_PIV_RD : S_POP;
            end
            S_PIV_RD: begin
                el_raddr = mid_sum[IW:1];
                n_state  = S_PIV_GET;
            end
            S_PIV_GET: begin
                n_pivot = el_rdata;
                n_l     = s_lo;
                n_h     = s_hi;
                n_state = S_LOOP;
            end
            S_LOOP: begin
                n_state = (r_l <= r_h) ? S_L_RD : S_PUSH1;
            end
            S_L_RD: begin
                el_raddr = r_l[IW-1:0];
                n_state  = S_L_CHK;
            end
            S_L_CHK: begin
                if ((r_l < s_hi) && cmp_lt) begin
                    n_l     = r_l + PW'(1);
                    n_state = S_L_RD;
                end else begin
                    n_vl    = el_rdata;
                    n_state = S_H_RD;
                end
            end
            S_H_RD: begin
                el_raddr = r_h[IW-1:0];
                n_state  = S_H_CHK;
            end
            S_H_CHK: begin
                if ((r_h > s_lo) && cmp_lt) begin
                    n_h     = r_h - PW'(1);
                    n_state = S_H_RD;
                end else begin
                    n_vh    = el_rdata;
                    n_state = S_SWAP_L;
                end
            end
            S_SWAP_L: begin
                if (r_l <= r_h) begin
                    el_we    = 1'b1;
                    el_waddr = r_l[IW-1:0];
                    el_wdata = r_vh;
                    n_state  = S_SWAP_H;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_SWAP_H: begin
                el_we    = 1'b1;
                el_waddr = r_h[IW-1:0];
                el_wdata = r_vl;
                n_l      = r_l + PW'(1);
                n_h      = r_h - PW'(1);
                n_state  = S_LOOP;
            end
            S_PUSH1, S_PUSH2: begin
                if (push_ok) begin
                    stk_we = 1'b1;
                    n_sp   = r_sp + CW'(1);
                end
                n_state = (r_state == S_PUSH1) ? S_PUSH2 : S_POP;
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_k     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_sp    = sp_m1;
                    n_state = S_POP_GET;
                end
            end
            S_POP_GET: begin
                n_lo    = stk_rdata[2*IW-1:IW];
                n_hi    = stk_rdata[IW-1:0];
                n_state = S_PIV_RD;
            end
            S_OUT_RD: begin
                el_raddr = r_k[IW-1:0];
                n_state  = S_OUT_GET;
            end
            S_OUT_GET: begin
                n_o_valid = 1'b1;
                n_o_data  = el_rdata;
                n_o_last  = (r_k == cnt_m1);
                n_o_ovf   = r_ovf;
                n_state   = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (i_ready) begin
                    n_o_valid = 1'b0;
                    if (r_o_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_sp      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_sp      <= n_sp;
            r_o_valid <= n_o_valid;
        end
        r_k      <= n_k;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_l      <= n_l;
        r_h      <= n_h;
        r_pivot  <= n_pivot;
        r_vl     <= n_vl;
        r_vh     <= n_vh;
        r_o_last <= n_o_last;
        r_o_ovf  <= n_o_ovf;
        r_o_data <= n_o_data;
    end

    assign o_ready        = (r_state == S_LOAD);
    assign o_valid        = r_o_valid;
    assign o_sorted_value = $signed(r_o_data);
    assign o_last_out     = r_o_last;
    assign o_overflowed   = r_o_ovf;

    `QHS_ASSERT_IMPL(a_no_load_while_out, o_valid, !o_ready)
    `QHS_ASSERT_IMPL(a_count_bound, 1'b1, (r_count <= CW'(DEPTH)) && (r_sp <= CW'(DEPTH)))
    `QHS_ASSERT_NEXT(a_run_clears, o_valid && i_ready && o_last_out,
        (r_count == '0) && !r_ovf && o_ready)
    `QHS_ASSERT_IMPL(a_low_scan_in_range, r_state == S_L_RD, (r_l >= s_lo) && (r_l <= s_hi))
    `QHS_ASSERT_IMPL(a_high_scan_in_range, r_state == S_H_RD, (r_h >= s_lo) && (r_h <= s_hi))

endmodule
